// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the heading estimator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SHE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SHE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/she_pkg.sv =====
// Package for the smoothed heading estimator: widths, CORDIC constants,
// arctangent table and the controller/datapath interface structs. No dependencies.
package she_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int VEL_WIDTH     = SAMPLE_WIDTH + 2;
  localparam int DIFF_WIDTH    = SAMPLE_WIDTH + 3;
  localparam int HEADING_WIDTH = 16;
  localparam int GUARD_BITS    = 24;
  localparam int ANGLE_FRAC    = 16;
  localparam int OUT_FRAC      = 7;
  // vector plus guard bits, with headroom for CORDIC gain and diagonal growth
  localparam int CORDIC_WIDTH  = DIFF_WIDTH + GUARD_BITS + 3;
  localparam int ANGLE_WIDTH   = 26;
  localparam int STEP_WIDTH    = $clog2(CORDIC_STEPS);
  localparam int ATAN_WIDTH    = 22;
  localparam int ATAN_DEPTH    = 24;
  localparam int ATAN_IDX_WIDTH = $clog2(ATAN_DEPTH);
  localparam int ROUND_SHIFT   = ANGLE_FRAC - OUT_FRAC;
  localparam int HROUND_WIDTH  = ANGLE_WIDTH - ROUND_SHIFT;

  localparam logic signed [ANGLE_WIDTH-1:0] HALF_TURN =
    ANGLE_WIDTH'(180 * (2 ** ANGLE_FRAC));
  localparam logic signed [ANGLE_WIDTH-1:0] FULL_TURN =
    ANGLE_WIDTH'(360 * (2 ** ANGLE_FRAC));
  localparam logic signed [ANGLE_WIDTH-1:0] ROUND_HALF =
    ANGLE_WIDTH'(2 ** (ROUND_SHIFT - 1));
  localparam logic [HROUND_WIDTH-1:0] OUT_TURN =
    HROUND_WIDTH'(360 * (2 ** OUT_FRAC));

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  localparam logic [ATAN_WIDTH-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  typedef struct packed {
    logic accept;
    logic init;
    logic step;
    logic finish;
  } she_cmd_t;

  typedef struct packed {
    logic last_step;
  } she_status_t;

endpackage

// ===== hw/rtl/she_ctrl.sv =====
// Controller for the smoothed heading estimator: sequences accept, CORDIC
// setup, iterations and result load. Depends on she_pkg and assert_macros.svh.
`include "assert_macros.svh"

module she_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output she_pkg::she_cmd_t     cmd,
  input  she_pkg::she_status_t  status
);
  import she_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INIT   = 4'b0010,
    S_ITER   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd        = '0;
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.init   = (state_r == S_INIT);
    cmd.step   = (state_r == S_ITER);
    // result register is free, or its transaction completes this cycle
    cmd.finish = (state_r == S_FINISH) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (cmd.accept) state_nxt = S_INIT;
      S_INIT:   state_nxt = S_ITER;
      S_ITER:   if (status.last_step) state_nxt = S_FINISH;
      S_FINISH: if (cmd.finish) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `SHE_ASSERT_NXT(a_accept_to_init, clk, rst_n, cmd.accept, state_r == S_INIT)
  `SHE_ASSERT_NXT(a_last_to_finish, clk, rst_n, cmd.step && status.last_step, state_r == S_FINISH)
  `SHE_ASSERT_NXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_r && state_r == S_IDLE)

endmodule

// ===== hw/rtl/she_datapath.sv =====
// Datapath for the smoothed heading estimator: 1-2-1 smoothing history,
// velocity difference, iterative CORDIC vectoring and result register. Uses she_pkg.
module she_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  she_pkg::she_cmd_t                      cmd,
  output she_pkg::she_status_t                   status,
  input  logic signed [she_pkg::SAMPLE_WIDTH-1:0] in_sample_y,
  input  logic signed [she_pkg::SAMPLE_WIDTH-1:0] in_sample_z,
  output logic signed [she_pkg::VEL_WIDTH-1:0]    out_velocity_y,
  output logic signed [she_pkg::VEL_WIDTH-1:0]    out_velocity_z,
  output logic [she_pkg::HEADING_WIDTH-1:0]       out_heading,
  output logic                                   out_no_motion
);
  import she_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] older_y_r, newer_y_r, older_z_r, newer_z_r;
  logic signed [VEL_WIDTH-1:0]    last_smooth_y_r, last_smooth_z_r;
  logic signed [DIFF_WIDTH-1:0]   dy_r, dz_r;
  logic signed [CORDIC_WIDTH-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ANGLE_WIDTH-1:0]  ang_r, ang_nxt;
  logic [STEP_WIDTH-1:0]          step_r;
  logic                           still_r;

  logic signed [VEL_WIDTH-1:0]    smooth_y, smooth_z;
  logic signed [DIFF_WIDTH-1:0]   diff_y, diff_z;
  logic signed [CORDIC_WIDTH-1:0] x0, y0, xs, ys;
  logic signed [ANGLE_WIDTH-1:0]  atan_val, ang_pos, ang_rnd;
  logic [HROUND_WIDTH-1:0]        h_raw, h_wrap;
  logic signed [VEL_WIDTH-1:0]    sat_y, sat_z;

  logic signed [VEL_WIDTH-1:0] vel_y_r, vel_z_r;
  logic [HEADING_WIDTH-1:0]    heading_r;
  logic                        no_motion_r;

  // smoothed sum kept undivided: quarter input LSB units
  assign smooth_y = VEL_WIDTH'(older_y_r) + (VEL_WIDTH'(newer_y_r) <<< 1)
                  + VEL_WIDTH'(in_sample_y);
  assign smooth_z = VEL_WIDTH'(older_z_r) + (VEL_WIDTH'(newer_z_r) <<< 1)
                  + VEL_WIDTH'(in_sample_z);
  assign diff_y = DIFF_WIDTH'(smooth_y) - DIFF_WIDTH'(last_smooth_y_r);
  assign diff_z = DIFF_WIDTH'(smooth_z) - DIFF_WIDTH'(last_smooth_z_r);

  assign x0 = CORDIC_WIDTH'(dy_r) <<< GUARD_BITS;
  assign y0 = CORDIC_WIDTH'(dz_r) <<< GUARD_BITS;

  assign xs       = x_r >>> step_r;
  assign ys       = y_r >>> step_r;
  assign atan_val = ANGLE_WIDTH'(ATAN_TAB[ATAN_IDX_WIDTH'(step_r)]);

  always_comb begin
    if (!y_r[CORDIC_WIDTH-1]) begin
      x_nxt   = x_r + ys;
      y_nxt   = y_r - xs;
      ang_nxt = ang_r + atan_val;
    end else begin
      x_nxt   = x_r - ys;
      y_nxt   = y_r + xs;
      ang_nxt = ang_r - atan_val;
    end
  end

  assign status.last_step = (step_r == STEP_WIDTH'(CORDIC_STEPS - 1));

  // angle only ever falls below zero, never reaches a full turn
  assign ang_pos = ang_r[ANGLE_WIDTH-1] ? ang_r + FULL_TURN : ang_r;
  assign ang_rnd = ang_pos + ROUND_HALF;
  assign h_raw   = HROUND_WIDTH'(ang_rnd >>> ROUND_SHIFT);
  assign h_wrap  = (h_raw >= OUT_TURN) ? h_raw - OUT_TURN : h_raw;

  always_comb begin
    sat_y = dy_r[VEL_WIDTH-1:0];
    if (dy_r[DIFF_WIDTH-1] != dy_r[DIFF_WIDTH-2])
      sat_y = dy_r[DIFF_WIDTH-1] ? {1'b1, {(VEL_WIDTH-1){1'b0}}}
                                 : {1'b0, {(VEL_WIDTH-1){1'b1}}};
    sat_z = dz_r[VEL_WIDTH-1:0];
    if (dz_r[DIFF_WIDTH-1] != dz_r[DIFF_WIDTH-2])
      sat_z = dz_r[DIFF_WIDTH-1] ? {1'b1, {(VEL_WIDTH-1){1'b0}}}
                                 : {1'b0, {(VEL_WIDTH-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_y_r       <= '0;
      newer_y_r       <= '0;
      older_z_r       <= '0;
      newer_z_r       <= '0;
      last_smooth_y_r <= '0;
      last_smooth_z_r <= '0;
    end else if (cmd.accept) begin
      older_y_r       <= newer_y_r;
      newer_y_r       <= in_sample_y;
      older_z_r       <= newer_z_r;
      newer_z_r       <= in_sample_z;
      last_smooth_y_r <= smooth_y;
      last_smooth_z_r <= smooth_z;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dy_r <= diff_y;
      dz_r <= diff_z;
    end
    if (cmd.init) begin
      step_r  <= '0;
      still_r <= (dy_r == '0) && (dz_r == '0);
      if (dy_r[DIFF_WIDTH-1]) begin
        x_r   <= -x0;
        y_r   <= -y0;
        ang_r <= HALF_TURN;
      end else begin
        x_r   <= x0;
        y_r   <= y0;
        ang_r <= '0;
      end
    end else if (cmd.step) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      step_r <= step_r + 1'b1;
    end
    if (cmd.finish) begin
      vel_y_r     <= sat_y;
      vel_z_r     <= sat_z;
      heading_r   <= still_r ? '0 : HEADING_WIDTH'(h_wrap);
      no_motion_r <= still_r;
    end
  end

  assign out_velocity_y = vel_y_r;
  assign out_velocity_z = vel_z_r;
  assign out_heading    = heading_r;
  assign out_no_motion  = no_motion_r;

endmodule

// ===== hw/rtl/smoothed_heading_estimator.sv =====
// Smoothed heading estimator, top level: joins controller and datapath.
// Depends on she_pkg, she_ctrl, she_datapath and assert_macros.svh.
//
// Each accepted transaction carries one (y, z) position sample; one result
// follows per sample with the 1-2-1 smoothed velocity (saturated to 18 bits)
// and its heading atan2(vz, vy) in degrees, Q9.7 in [0, 360). Zero velocity
// sets no_motion and gives heading 0. Each item passes through accept,
// vector setup, the CORDIC iterations on a single shared shift-add
// stage, and the rounding and load of the result register. A new sample
// is taken once the result is loaded, even while that result still waits
// on out_stall; a stalled result delays loading of the next one. History
// starts at zero after reset.
`include "assert_macros.svh"

module smoothed_heading_estimator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [she_pkg::SAMPLE_WIDTH-1:0] in_sample_y,
  input  logic signed [she_pkg::SAMPLE_WIDTH-1:0] in_sample_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [she_pkg::VEL_WIDTH-1:0]    out_velocity_y,
  output logic signed [she_pkg::VEL_WIDTH-1:0]    out_velocity_z,
  output logic [she_pkg::HEADING_WIDTH-1:0]       out_heading,
  output logic                                   out_no_motion
);
  import she_pkg::*;

  she_cmd_t    cmd;
  she_status_t status;

  she_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  she_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .out_velocity_y (out_velocity_y),
    .out_velocity_z (out_velocity_z),
    .out_heading    (out_heading),
    .out_no_motion  (out_no_motion)
  );

  `SHE_ASSERT_IMP(a_heading_range, clk, rst_n, out_valid, out_heading < HEADING_WIDTH'(OUT_TURN))
  `SHE_ASSERT_IMP(a_still_heading, clk, rst_n, out_valid && out_no_motion, out_heading == '0)

endmodule

// ===== verif/heading_checker.sv =====
// Scoreboard for the smoothed heading estimator: watches both channels,
// predicts velocity and heading per sample and compares each result.
// Depends on she_pkg for the channel widths and the CORDIC step count.
module heading_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic signed [she_pkg::SAMPLE_WIDTH-1:0] in_sample_y,
  input  logic signed [she_pkg::SAMPLE_WIDTH-1:0] in_sample_z,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic signed [she_pkg::VEL_WIDTH-1:0]    out_velocity_y,
  input  logic signed [she_pkg::VEL_WIDTH-1:0]    out_velocity_z,
  input  logic [she_pkg::HEADING_WIDTH-1:0]       out_heading,
  input  logic                                    out_no_motion,
  output int unsigned                             mismatches,
  output int unsigned                             results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import she_pkg::*;

  localparam int     GUARD      = 24;
  localparam int     DEG_FRAC   = 16;
  localparam int     HEAD_FRAC  = 7;
  localparam longint TURN_FINE  = 64'sd360 <<< DEG_FRAC;
  localparam longint HALF_FINE  = 64'sd180 <<< DEG_FRAC;
  localparam longint TURN_HEAD  = 64'sd360 <<< HEAD_FRAC;

  typedef struct {
    logic signed [VEL_WIDTH-1:0] vel_y;
    logic signed [VEL_WIDTH-1:0] vel_z;
    logic [HEADING_WIDTH-1:0]    heading;
    logic                        no_motion;
  } motion_t;

  // atan(2^-i) in degrees, 16 fractional bits
  longint atan_deg [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  motion_t expected_motion [$];
  longint  y_back1, y_back2, z_back1, z_back2;
  longint  smooth_y_prev, smooth_z_prev;

  function automatic logic signed [VEL_WIDTH-1:0] clamp_velocity(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (VEL_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return VEL_WIDTH'(v);
  endfunction

  // vectoring CORDIC on the exact difference, angle wrapped into one turn
  function automatic logic [HEADING_WIDTH-1:0] heading_of_motion(input longint dy,
                                                                  input longint dz);
    longint x;
    longint y;
    longint ang;
    longint xs;
    longint ys;
    longint h;
    x   = dy <<< GUARD;
    y   = dz <<< GUARD;
    ang = 0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      ang = HALF_FINE;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        ang = ang + atan_deg[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        ang = ang - atan_deg[i];
      end
    end
    while (ang < 0) ang = ang + TURN_FINE;
    while (ang >= TURN_FINE) ang = ang - TURN_FINE;
    h = (ang + (64'sd1 <<< (DEG_FRAC - HEAD_FRAC - 1))) >>> (DEG_FRAC - HEAD_FRAC);
    if (h >= TURN_HEAD) h = h - TURN_HEAD;
    return HEADING_WIDTH'(h);
  endfunction

  task automatic compare_field(input string what, input longint want,
                               input logic signed [31:0] got);
    if (got !== 32'(want)) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    motion_t want;
    longint  sy;
    longint  sz;
    longint  smy;
    longint  smz;
    longint  dy;
    longint  dz;
    if (!rst_n) begin
      expected_motion.delete();
      mismatches    = 0;
      y_back1       = 0;
      y_back2       = 0;
      z_back1       = 0;
      z_back2       = 0;
      smooth_y_prev = 0;
      smooth_z_prev = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_motion.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with nothing expected, expected none, got %0d",
                   $time, out_heading);
        end else begin
          want = expected_motion.pop_front();
          compare_field("velocity_y", want.vel_y, out_velocity_y);
          compare_field("velocity_z", want.vel_z, out_velocity_z);
          compare_field("heading", want.heading, out_heading);
          compare_field("no_motion", want.no_motion, out_no_motion);
        end
      end
      if (in_valid && !in_stall) begin
        sy  = in_sample_y;
        sz  = in_sample_z;
        smy = y_back2 + 2 * y_back1 + sy;
        smz = z_back2 + 2 * z_back1 + sz;
        dy  = smy - smooth_y_prev;
        dz  = smz - smooth_z_prev;
        y_back2       = y_back1;
        y_back1       = sy;
        z_back2       = z_back1;
        z_back1       = sz;
        smooth_y_prev = smy;
        smooth_z_prev = smz;
        want.vel_y     = clamp_velocity(dy);
        want.vel_z     = clamp_velocity(dz);
        want.no_motion = (dy == 0 && dz == 0);
        want.heading   = want.no_motion ? '0 : heading_of_motion(dy, dz);
        expected_motion.push_back(want);
      end
    end
    results_due = expected_motion.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the heading estimator testbench: clock, reset, sample stimulus,
// result back-pressure and the verdict. Depends on she_pkg, heading_checker and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = she_pkg::SAMPLE_WIDTH;
  localparam int VW = she_pkg::VEL_WIDTH;
  localparam int HW = she_pkg::HEADING_WIDTH;
  localparam int RANDOM_SAMPLES = 700;
  localparam int HOLD_CYCLES    = 160;
  localparam int DRAIN_CYCLES   = 40;
  localparam int S_MAX          = 32767;
  localparam int S_MIN          = -32768;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] in_sample_y;
  logic signed [SW-1:0] in_sample_z;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [VW-1:0] out_velocity_y;
  logic signed [VW-1:0] out_velocity_z;
  logic [HW-1:0]        out_heading;
  logic                 out_no_motion;
  int unsigned          mismatches;
  int unsigned          results_due;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  // standing still, single-axis steps, wrap just below 360, full-scale swings
  int dir_y [24] = '{0, 0, 1, 1, 1, 1, 1, 0, -1, -1, -1, -1,
                     S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN,
                     S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX};
  int dir_z [24] = '{0, 0, 0, 0, 0, 0, -1, -1, 0, 0, 0, 0,
                     0, -1, S_MIN, S_MIN, S_MIN, S_MIN,
                     S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  smoothed_heading_estimator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_velocity_y (out_velocity_y),
    .out_velocity_z (out_velocity_z),
    .out_heading    (out_heading),
    .out_no_motion  (out_no_motion)
  );

  heading_checker u_heading_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_velocity_y (out_velocity_y),
    .out_velocity_z (out_velocity_z),
    .out_heading    (out_heading),
    .out_no_motion  (out_no_motion),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (calm || !rst_n) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 8);
      end
    end
  end

  task automatic send_sample(input int y, input int z);
    in_valid    <= 1'b1;
    in_sample_y <= SW'(y);
    in_sample_z <= SW'(z);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic int pick_coord(input int prev);
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 50) begin
      v = prev + int'($urandom_range(128)) - 64;
    end else if (r < 65) begin
      v = prev;
    end else if (r < 80) begin
      case ($urandom_range(4))
        0:       v = S_MAX;
        1:       v = S_MIN;
        2:       v = 0;
        3:       v = 1;
        default: v = -1;
      endcase
    end else begin
      v = int'($signed(16'($urandom)));
    end
    if (v > S_MAX) v = S_MAX;
    if (v < S_MIN) v = S_MIN;
    return v;
  endfunction

  initial begin
    int y;
    int z;
    int still_run;
    in_valid    <= 1'b0;
    in_sample_y <= '0;
    in_sample_z <= '0;
    rst_n       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_y[i]) begin
      send_sample(dir_y[i], dir_z[i]);
      maybe_idle();
    end

    y = 0;
    z = 0;
    still_run = 0;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n == 250) calm = 1'b1;
      if (n == 350) calm = 1'b0;
      if (n == 400) hold_req = 1'b1;
      if (n == 440) begin
        // let every outstanding result come out before carrying on
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
      end
      if (still_run > 0) begin
        still_run--;
      end else if ($urandom_range(99) < 5) begin
        still_run = $urandom_range(2, 5);
      end else begin
        y = pick_coord(y);
        z = pick_coord(z);
      end
      send_sample(y, z);
      maybe_idle();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== smoothed_heading_estimator.f =====
+incdir+hw/rtl
hw/rtl/she_pkg.sv
hw/rtl/she_ctrl.sv
hw/rtl/she_datapath.sv
hw/rtl/smoothed_heading_estimator.sv
verif/heading_checker.sv
verif/tb_top.sv
